// File: src/kvlp_pkg.sv
// ----------------------------------------------------------------------------
// kvlp_pkg: shared definitions for the key/value line parser
// Line buffer size, phase and verdict codes, configuration register indexes
// and their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package kvlp_pkg;

    // Size of the line buffer; a line closes once BUFFER_BYTES-1 bytes are stored.
    localparam int BUFFER_BYTES = 32;
    localparam int CNT_W        = $clog2(BUFFER_BYTES);

    typedef logic [CNT_W-1:0] count_t;

    localparam count_t FULL_COUNT = CNT_W'(BUFFER_BYTES - 1);

    // Parser phase within one line.
    typedef enum logic [2:0] {
        PH_KEY   = 3'd0,
        PH_SPLIT = 3'd1,
        PH_VALUE = 3'd2,
        PH_GET   = 3'd3,
        PH_ENDED = 3'd4
    } phase_t;

    // Verdict reported when a line closes.
    typedef enum logic [1:0] {
        VERDICT_DISCARD = 2'd0,
        VERDICT_GET     = 2'd1,
        VERDICT_SET     = 2'd2
    } verdict_t;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_SPLIT_CHAR = 2'd0;
    localparam cfg_index_t CFG_QUERY_CHAR = 2'd1;
    localparam cfg_index_t CFG_TERM_CHAR  = 2'd2;

    localparam logic [7:0] SPLIT_CHAR_RESET = 8'd44;
    localparam logic [7:0] QUERY_CHAR_RESET = 8'd63;
    localparam logic [7:0] TERM_CHAR_RESET  = 8'd10;

    // ASCII code of the digit zero.
    localparam logic [31:0] ASCII_ZERO = 32'd48;

endpackage

`default_nettype wire

// File: src/key_value_line_parser_top.sv
// ----------------------------------------------------------------------------
// key_value_line_parser_top: key/value line parser
// Output: each result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the result register is free or drained; the parser
// state registers update in the cycle a byte is accepted, so the state feedback sets the rate.
// Reset: asynchronous, active low. It clears the line state and restores the
// split, query and terminator characters to comma, question mark and newline.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_line_parser_top (
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // Configuration write channel.
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire kvlp_pkg::cfg_index_t    cfg_index,
    input  wire logic [7:0]              cfg_data,

    // Received byte channel.
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [7:0]              rx_byte,

    // Result channel.
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         key_char_valid,
    output logic [7:0]                   key_char,
    output logic                         line_done,
    output logic [1:0]                   verdict,
    output logic signed [31:0]           set_value
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; software must only write them while no
    // line traffic is in flight, and the block itself does not enforce this.
    // ------------------------------------------------------------------
    logic [7:0] split_char_reg;
    logic [7:0] query_char_reg;
    logic [7:0] term_char_reg;
    logic       cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_char_reg <= kvlp_pkg::SPLIT_CHAR_RESET;
            query_char_reg <= kvlp_pkg::QUERY_CHAR_RESET;
            term_char_reg  <= kvlp_pkg::TERM_CHAR_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                kvlp_pkg::CFG_SPLIT_CHAR: split_char_reg <= cfg_data;
                kvlp_pkg::CFG_QUERY_CHAR: query_char_reg <= cfg_data;
                kvlp_pkg::CFG_TERM_CHAR:  term_char_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Line state: stored byte count, phase and decimal accumulator.
    // ------------------------------------------------------------------
    kvlp_pkg::count_t count_reg,  count_next;
    kvlp_pkg::phase_t phase_reg,  phase_next;
    logic [31:0]      acc_reg,    acc_next;

    // Result register, loaded whenever a byte is accepted.
    logic             out_valid_reg;
    logic             key_valid_reg,  key_valid_next;
    logic [7:0]       key_char_reg,   key_char_next;
    logic             done_reg,       done_next;
    logic [1:0]       verdict_reg,    verdict_next;
    logic [31:0]      value_reg,      value_next;

    logic             in_fire;
    logic             term_hit;
    logic             zero_byte;
    logic [31:0]      acc_step;
    kvlp_pkg::count_t count_inc;
    kvlp_pkg::phase_t phase_upd;
    logic [31:0]      acc_upd;

    // The result register frees up in the same cycle it is drained, so a
    // new byte can be taken while the previous result is being consumed.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign term_hit  = (rx_byte == term_char_reg);
    assign zero_byte = (rx_byte == 8'd0);
    assign count_inc = count_reg + kvlp_pkg::count_t'(1);

    // value = 10 * value + (c - '0'), wrapping in 32 bits. Non-digit bytes
    // are not checked.
    assign acc_step = (acc_reg << 3) + (acc_reg << 1) + {24'd0, rx_byte}
                      - kvlp_pkg::ASCII_ZERO;

    always_comb
    begin
        phase_upd      = phase_reg;
        acc_upd        = acc_reg;
        key_valid_next = 1'b0;
        key_char_next  = 8'd0;
        done_next      = 1'b0;
        verdict_next   = kvlp_pkg::VERDICT_DISCARD;
        value_next     = 32'd0;
        count_next     = count_reg;

        if (term_hit)
        begin
            // The terminator wins over every other role and is not stored.
            done_next = 1'b1;
        end
        else
        begin
            count_next = count_inc;
            case (phase_reg)
                kvlp_pkg::PH_KEY:
                begin
                    // A zero byte in the key acts as the split.
                    if (rx_byte == split_char_reg || zero_byte)
                    begin
                        phase_upd = kvlp_pkg::PH_SPLIT;
                    end
                    else
                    begin
                        key_valid_next = 1'b1;
                        key_char_next  = rx_byte;
                    end
                end
                kvlp_pkg::PH_SPLIT:
                begin
                    if (rx_byte == query_char_reg)
                    begin
                        phase_upd = kvlp_pkg::PH_GET;
                    end
                    else if (zero_byte)
                    begin
                        phase_upd = kvlp_pkg::PH_ENDED;
                    end
                    else
                    begin
                        acc_upd   = acc_step;
                        phase_upd = kvlp_pkg::PH_VALUE;
                    end
                end
                kvlp_pkg::PH_VALUE:
                begin
                    if (zero_byte)
                    begin
                        phase_upd = kvlp_pkg::PH_ENDED;
                    end
                    else
                    begin
                        acc_upd = acc_step;
                    end
                end
                default:
                begin
                    // Get request or ended value: remaining bytes are ignored.
                end
            endcase

            // The byte that fills the buffer also closes the line.
            if (count_inc == kvlp_pkg::FULL_COUNT)
            begin
                done_next = 1'b1;
            end
        end

        phase_next = phase_upd;
        acc_next   = acc_upd;

        if (done_next)
        begin
            if (phase_upd == kvlp_pkg::PH_GET)
            begin
                verdict_next = kvlp_pkg::VERDICT_GET;
            end
            else if (phase_upd inside {kvlp_pkg::PH_VALUE, kvlp_pkg::PH_ENDED})
            begin
                verdict_next = kvlp_pkg::VERDICT_SET;
                value_next   = acc_upd;
            end
            count_next = '0;
            phase_next = kvlp_pkg::PH_KEY;
            acc_next   = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            phase_reg <= kvlp_pkg::PH_KEY;
            acc_reg   <= 32'd0;
        end
        else if (in_fire)
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_valid_reg <= key_valid_next;
            key_char_reg  <= key_char_next;
            done_reg      <= done_next;
            verdict_reg   <= verdict_next;
            value_reg     <= value_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign key_char_valid = key_valid_reg;
    assign key_char       = key_char_reg;
    assign line_done      = done_reg;
    assign verdict        = verdict_reg;
    assign set_value      = signed'(value_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The stored count never reaches the full mark; that byte closes the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != kvlp_pkg::FULL_COUNT)
        else $error("stored count reached the full mark");

    // A closing byte always returns the line state to the key phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && done_next |=> count_reg == '0 && phase_reg == kvlp_pkg::PH_KEY
                                 && acc_reg == 32'd0)
        else $error("line state not cleared after close");

    // Verdict and value are zero unless the result closes a line.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !line_done |-> verdict == kvlp_pkg::VERDICT_DISCARD
                                    && set_value == 32'sd0)
        else $error("verdict or value set without line close");

    // A key character is only reported while in the key phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && key_valid_next |-> phase_reg == kvlp_pkg::PH_KEY && !term_hit)
        else $error("key character outside key phase");

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the key/value line parser
// Sends directed lines and then random lines until about 1100 bytes have gone
// in, mostly well-formed, with random key, query and value content. The sender
// and the receiver both idle at random. Every accepted byte is run through a
// line predictor, and each result transaction is compared field by field with
// the oldest expectation. The split, query and terminator characters are
// rewritten between phases, with their extremes and with colliding settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // If no transaction of any kind happens for this many cycles, the run is
    // declared hung.
    localparam int STALL_LIMIT = 1000;

    // One result transaction, as predicted or as seen on the outputs.
    typedef struct packed {
        logic        key_valid;
        logic [7:0]  key_byte;
        logic        done;
        logic [1:0]  verdict;
        logic [31:0] value;
    } line_result_t;

    // ------------------------------------------------------------------------
    // Line predictor and result store. note_byte() runs one accepted byte
    // through the line state and queues the result it must produce;
    // check_result() compares a received result with the oldest one queued.
    // ------------------------------------------------------------------------
    class line_scoreboard;
        logic [7:0]        split_c;
        logic [7:0]        query_c;
        logic [7:0]        term_c;
        int                stored;
        kvlp_pkg::phase_t  line_phase;
        logic [31:0]       acc;
        line_result_t      expected_q[$];
        int                errors;
        int                n_checked;

        function new();
            split_c    = kvlp_pkg::SPLIT_CHAR_RESET;
            query_c    = kvlp_pkg::QUERY_CHAR_RESET;
            term_c     = kvlp_pkg::TERM_CHAR_RESET;
            stored     = 0;
            line_phase = kvlp_pkg::PH_KEY;
            acc        = '0;
            errors     = 0;
            n_checked  = 0;
        endfunction

        function void write_reg(kvlp_pkg::cfg_index_t idx, logic [7:0] data);
            case (idx)
                kvlp_pkg::CFG_SPLIT_CHAR: split_c = data;
                kvlp_pkg::CFG_QUERY_CHAR: query_c = data;
                kvlp_pkg::CFG_TERM_CHAR:  term_c  = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // The verdict depends only on how far the line got.
        function void close_line(inout line_result_t r);
            r.done = 1'b1;
            if (line_phase == kvlp_pkg::PH_GET)
            begin
                r.verdict = kvlp_pkg::VERDICT_GET;
            end
            else if (line_phase == kvlp_pkg::PH_VALUE || line_phase == kvlp_pkg::PH_ENDED)
            begin
                r.verdict = kvlp_pkg::VERDICT_SET;
                r.value   = acc;
            end
            stored     = 0;
            line_phase = kvlp_pkg::PH_KEY;
            acc        = '0;
        endfunction

        // Digits are not checked: any byte is taken as c - '0' with wrap.
        function void add_digit(logic [7:0] c);
            acc = acc * 32'd10 + {24'd0, c} - kvlp_pkg::ASCII_ZERO;
        endfunction

        function void note_byte(logic [7:0] c);
            line_result_t r;
            r = '0;
            // The terminator wins over every other role of the byte.
            if (c == term_c)
            begin
                close_line(r);
            end
            else
            begin
                stored++;
                case (line_phase)
                    kvlp_pkg::PH_KEY:
                    begin
                        if (c == split_c || c == 8'd0)
                        begin
                            line_phase = kvlp_pkg::PH_SPLIT;
                        end
                        else
                        begin
                            r.key_valid = 1'b1;
                            r.key_byte  = c;
                        end
                    end
                    kvlp_pkg::PH_SPLIT:
                    begin
                        if (c == query_c)
                        begin
                            line_phase = kvlp_pkg::PH_GET;
                        end
                        else if (c == 8'd0)
                        begin
                            line_phase = kvlp_pkg::PH_ENDED;
                        end
                        else
                        begin
                            add_digit(c);
                            line_phase = kvlp_pkg::PH_VALUE;
                        end
                    end
                    kvlp_pkg::PH_VALUE:
                    begin
                        if (c == 8'd0)
                        begin
                            line_phase = kvlp_pkg::PH_ENDED;
                        end
                        else
                        begin
                            add_digit(c);
                        end
                    end
                    default: ;
                endcase
                // A full buffer closes the line in the same result.
                if (stored >= kvlp_pkg::BUFFER_BYTES - 1)
                begin
                    close_line(r);
                end
            end
            expected_q.push_back(r);
        endfunction

        function void report(string field, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v)
            begin
                $display("%0t ns: result %0d, %s expected %0d (0x%h) got %0d (0x%h)",
                         $time, n_checked, field, exp_v, exp_v, got_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(line_result_t got);
            line_result_t exp;
            if (expected_q.size() == 0)
            begin
                $display("%0t ns: result with nothing expected, expected none got %h",
                         $time, got);
                errors++;
            end
            else
            begin
                exp = expected_q.pop_front();
                report("key_char_valid", 32'(exp.key_valid), 32'(got.key_valid));
                report("key_char", 32'(exp.key_byte), 32'(got.key_byte));
                report("line_done", 32'(exp.done), 32'(got.done));
                report("verdict", 32'(exp.verdict), 32'(got.verdict));
                report("set_value", exp.value, got.value);
            end
            n_checked++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the DUT. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    kvlp_pkg::cfg_index_t  cfg_index = kvlp_pkg::CFG_SPLIT_CHAR;
    logic [7:0]            cfg_data = 8'd0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [7:0]            rx_byte = 8'd0;

    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  key_char_valid;
    logic [7:0]            key_char;
    logic                  line_done;
    logic [1:0]            verdict;
    logic signed [31:0]    set_value;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    key_value_line_parser_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .key_char_valid (key_char_valid),
        .key_char       (key_char),
        .line_done      (line_done),
        .verdict        (verdict),
        .set_value      (set_value)
    );

    line_scoreboard sb = new();

    // Stimulus-side copy of the special characters, so that random lines are
    // built around the current setting.
    logic [7:0] cur_split = kvlp_pkg::SPLIT_CHAR_RESET;
    logic [7:0] cur_query = kvlp_pkg::QUERY_CHAR_RESET;
    logic [7:0] cur_term  = kvlp_pkg::TERM_CHAR_RESET;

    bit no_idle  = 1'b0;   // both sides stop idling while set
    bit hold_req = 1'b0;   // asks the receiver for one long stall
    int bytes_sent = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------------
    // Monitor. Inputs only change at the rising edge, so the handshake values
    // seen at the falling edge are exactly those the next rising edge acts on.
    // This also serves as the watchdog.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        line_result_t got;
        bit           busy;
        busy = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            sb.write_reg(cfg_index, cfg_data);
            busy = 1'b1;
        end
        if (in_valid && in_ready)
        begin
            sb.note_byte(rx_byte);
            busy = 1'b1;
        end
        if (out_valid && out_ready)
        begin
            got = '{key_char_valid, key_char, line_done, verdict, set_value};
            sb.check_result(got);
            busy = 1'b1;
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Before each result it may drop ready at random, or for a
    // long stretch when asked, so that the parser backs up and stalls its
    // input while the sender keeps offering bytes.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        bit fire;
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (hold_req)
            begin
                stall    = 64;
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
            begin
                @(negedge clk);
                fire = out_valid;
                @(posedge clk);
            end while (!fire);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks. All of them start and end at a rising edge. Valid is left
    // high after a transaction so that back-to-back bytes need no extra
    // assignment; a gap lowers it first.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        bit fire;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
        begin
            @(negedge clk);
            fire = in_ready;
            @(posedge clk);
        end while (!fire);
        bytes_sent++;
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // Stop sending and wait until every expected result has come back, plus some margin.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Rewrites all three special characters while the parser is idle.
    task automatic set_chars(input logic [7:0] split, input logic [7:0] query,
                             input logic [7:0] term);
        kvlp_pkg::cfg_index_t idx[3];
        logic [7:0]           val[3];
        bit                   fire;
        idx = '{kvlp_pkg::CFG_SPLIT_CHAR, kvlp_pkg::CFG_QUERY_CHAR,
                kvlp_pkg::CFG_TERM_CHAR};
        val = '{split, query, term};
        drain_results();
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
            begin
                @(negedge clk);
                fire = cfg_ready;
                @(posedge clk);
            end while (!fire);
        end
        cfg_valid <= 1'b0;
        cur_split = split;
        cur_query = query;
        cur_term  = term;
    endtask

    // A key byte that is neither a split nor a terminator under the current
    // setting.
    function automatic logic [7:0] key_byte();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(1, 255));
        end while (b == cur_split || b == cur_term);
        return b;
    endfunction

    // One random line. Most lines are well-formed: key, split, then a query
    // or a run of digits, then the terminator. Some are pure noise, some have
    // no split, some stop without a terminator, and some are long enough to
    // fill the buffer.
    task automatic random_line();
        int         r;
        int         klen;
        int         vlen;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            return;
        end
        klen = (r < 16) ? $urandom_range(24, 34) : $urandom_range(0, 6);
        repeat (klen) send_byte(key_byte());
        if (r < 20)
        begin
            send_byte(cur_term);
            return;
        end
        // Now and then a zero byte takes the place of the split.
        send_byte(($urandom_range(0, 9) == 0) ? 8'd0 : cur_split);
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            send_byte(cur_query);
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
        end
        else if (r < 85)
        begin
            // Ten or more digits can run past 32 bits and wrap.
            vlen = (r < 42) ? $urandom_range(10, 14) : $urandom_range(1, 9);
            repeat (vlen)
            begin
                case ($urandom_range(0, 19))
                    0:       b = 8'd0;
                    1:       b = 8'($urandom);
                    default: b = 8'($urandom_range(48, 57));
                endcase
                send_byte(b);
            end
        end
        if ($urandom_range(0, 9) != 0)
        begin
            send_byte(cur_term);
        end
    endtask

    task automatic random_until(input int total);
        while (bytes_sent < total) random_line();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines under the reset characters: comma, question mark and
        // newline.
        send_byte(kvlp_pkg::TERM_CHAR_RESET);  // empty line is a discard
        send_str("a,?\n");                     // get request
        send_byte(8'hFF);                      // key bytes at both extremes
        send_byte(8'h01);
        send_str(",7\n");
        send_str("k\n");                       // no split seen
        send_str("k,\n");                      // nothing after the split
        send_byte(8'd0);                       // zero byte in the key splits it
        send_str("5\n");
        send_str(",");                         // zero right after the split
        send_byte(8'd0);
        send_str("\n");
        send_str(",1");                        // zero later ends the value
        send_byte(8'd0);
        send_str("9\n");
        send_str(",A\n");                      // non-digit is taken as c - '0'
        send_str(",9999999999\n");             // wraps in 32 bits

        // Reset setting, with one long receiver stall partway through.
        random_until(150);
        hold_req = 1'b1;
        random_until(330);

        // Zero split and zero query, terminator at the top of the range. The
        // sender pauses once until every result is back.
        set_chars(8'd0, 8'd0, 8'd255);
        random_until(450);
        drain_results();
        random_until(560);

        // Split and query at the top, zero as terminator; starts with a
        // stretch of no idling on either side.
        set_chars(8'd255, 8'd255, 8'd0);
        no_idle = 1'b1;
        random_until(660);
        no_idle = 1'b0;
        random_until(780);

        // Split and query are the same byte; that byte right after the split is the query.
        set_chars("=", "=", ";");
        random_until(950);

        // Terminator equals the split character: the terminator wins.
        set_chars(",", "?", ",");
        random_until(1100);

        drain_results();
        repeat (5) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results still expected", sb.errors, sb.pending());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
src/kvlp_pkg.sv
src/key_value_line_parser_top.sv
bench/testbench.sv
